// ===== rtl/vks_pkg.sv =====
// ----------------------------------------------------------------------------
// vks_pkg: shared types, constants and helpers of the vehicle kinematic step
// Holds the item structs, the CORDIC request and result structs, the arctan
// table and the fixed-point rounding and saturation helpers.
// ----------------------------------------------------------------------------
package vks_pkg;

   // Default parameter values.
   localparam int CORDIC_ITERATIONS_DEF      = 16;
   localparam int POSITION_FRACTION_BITS_DEF = 16;

   // Reset wheel base is twenty whole units in Q8.8.
   localparam int DEFAULT_WHEEL_BASE_UNITS = 20;
   localparam logic [15:0] WHEEL_BASE_RESET = 16'(DEFAULT_WHEEL_BASE_UNITS * 256);
   localparam logic [15:0] VELOCITY_RESET   = 16'd256;

   // CORDIC gain 1/K in Q30.
   localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

   // Datapath widths. The rotator width covers the largest length or difference
   // times 256, grown by the CORDIC gain.
   localparam int CORDIC_W     = 46;
   localparam int ANGLE_W      = 34;
   localparam int DELTA_W      = CORDIC_W - 8;
   localparam int ATAN_IDX_W   = 5;
   localparam int ATAN_W       = 30;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_BASE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VELOCITY      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_X       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_Y       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_HEADING = 3'd4;

   // Item commands.
   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_PLACE   = 1'b1;

   typedef enum logic {
      CM_POLAR  = 1'b0,
      CM_VECTOR = 1'b1
   } cordic_mode_type;

   typedef struct packed {
      logic               command;
      logic signed [15:0] steer_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] rear_x;
      logic signed [15:0] rear_y;
      logic signed [15:0] front_x;
      logic signed [15:0] front_y;
      logic signed [15:0] heading;
   } rsp_type;

   typedef struct packed {
      cordic_mode_type    mode;
      logic signed [16:0] len;
      logic [15:0]        angle;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
   } cordic_req_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] cx;
      logic signed [DELTA_W-1:0] cy;
      logic [15:0]               angle;
   } cordic_rsp_type;

   // atan(2^-i) as a 32-bit binary angle.
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] a;
      case (idx)
         5'd0:    a = 30'd536870912;
         5'd1:    a = 30'd316933406;
         5'd2:    a = 30'd167458907;
         5'd3:    a = 30'd85004756;
         5'd4:    a = 30'd42667331;
         5'd5:    a = 30'd21354465;
         5'd6:    a = 30'd10679838;
         5'd7:    a = 30'd5340245;
         5'd8:    a = 30'd2670163;
         5'd9:    a = 30'd1335087;
         5'd10:   a = 30'd667544;
         5'd11:   a = 30'd333772;
         5'd12:   a = 30'd166886;
         5'd13:   a = 30'd83443;
         5'd14:   a = 30'd41722;
         5'd15:   a = 30'd20861;
         5'd16:   a = 30'd10430;
         5'd17:   a = 30'd5215;
         5'd18:   a = 30'd2608;
         5'd19:   a = 30'd1304;
         5'd20:   a = 30'd652;
         5'd21:   a = 30'd326;
         5'd22:   a = 30'd163;
         5'd23:   a = 30'd81;
         default: a = '0;
      endcase
      return a;
   endfunction

   // Position plus CORDIC offset, saturated to the signed 32-bit range.
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [DELTA_W-1:0] b);
      logic signed [DELTA_W:0] s;
      logic [DELTA_W-31:0]     upper;
      logic signed [31:0]      r;
      s     = {{(DELTA_W-31){a[31]}}, a} + {b[DELTA_W-1], b};
      upper = s[DELTA_W:31];
      if ((&upper) || !(|upper)) begin
         r = s[31:0];
      end else if (s[DELTA_W]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   // Round a fixed-point position to whole units, half away from zero, and
   // saturate it to 16 bits.
   function automatic logic [15:0] round_coord(input logic signed [31:0] p,
                                               input int frac);
      logic [32:0] pe;
      logic [32:0] mag;
      logic [33:0] sum;
      logic [33:0] q;
      logic [15:0] r;
      pe  = {p[31], p};
      mag = p[31] ? (~pe + 33'd1) : pe;
      sum = {1'b0, mag} + (34'd1 << (frac - 1));
      q   = sum >> frac;
      if (!p[31]) begin
         r = (q > 34'd32767) ? 16'h7FFF : q[15:0];
      end else begin
         r = (q > 34'd32768) ? 16'h8000 : (~q[15:0] + 16'd1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/vks_cordic.sv =====
// ----------------------------------------------------------------------------
// vks_cordic: shared iterative CORDIC unit
// One micro-rotation per cycle. Polar mode turns a length and angle into an
// offset; vectoring mode turns a difference vector into a binary angle.
// ----------------------------------------------------------------------------
module vks_cordic
   import vks_pkg::*;
#(
   parameter int ITERATIONS = CORDIC_ITERATIONS_DEF,
   parameter int FRAC_BITS  = POSITION_FRACTION_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  cordic_req_type cmd,
   output logic           done,
   output cordic_rsp_type res
);

   localparam int LEN_SHIFT   = FRAC_BITS - 8;
   localparam int ROUND_SHIFT = 22 - LEN_SHIFT;
   localparam int PROD_W      = 48;
   localparam int CNT_W       = $clog2(ITERATIONS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(ITERATIONS - 1);
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (ROUND_SHIFT - 1));
   localparam logic signed [ANGLE_W-1:0] QUARTER   = ANGLE_W'(64'd1 << 30);
   localparam logic signed [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(64'd1 << 31);
   localparam logic signed [ANGLE_W-1:0] ANG_RND   = ANGLE_W'(64'd1 << 15);
   localparam logic signed [CORDIC_W-1:0] OUT_RND  = CORDIC_W'(128);

   typedef enum logic [3:0] {
      C_IDLE = 4'b0001,
      C_INIT = 4'b0010,
      C_ITER = 4'b0100,
      C_DONE = 4'b1000
   } cstate_type;

   cstate_type                  state_ff, state_in;
   cordic_mode_type             mode_ff, mode_in;
   logic signed [CORDIC_W-1:0]  x_ff, x_in;
   logic signed [CORDIC_W-1:0]  y_ff, y_in;
   logic signed [ANGLE_W-1:0]   z_ff, z_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;

   logic signed [PROD_W-1:0]    rnd;
   logic signed [CORDIC_W-1:0]  x0;
   logic signed [CORDIC_W-1:0]  sx, sy;
   logic signed [CORDIC_W-1:0]  dxe, dye;
   logic signed [ANGLE_W-1:0]   at;
   logic signed [CORDIC_W-1:0]  rx, ry;
   logic signed [ANGLE_W-1:0]   zr;
   logic                        pos;
   logic                        can_start;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;

      rnd = (prod_ff + ROUND_HALF) >>> ROUND_SHIFT;
      x0  = rnd[CORDIC_W-1:0];
      sx  = x_ff >>> cnt_ff;
      sy  = y_ff >>> cnt_ff;
      at  = {{(ANGLE_W-ATAN_W){1'b0}}, atan_entry(ATAN_IDX_W'(cnt_ff))};
      dxe = {{(CORDIC_W-33){cmd.dx[32]}}, cmd.dx} <<< 8;
      dye = {{(CORDIC_W-33){cmd.dy[32]}}, cmd.dy} <<< 8;
      // Polar turns towards z = 0; vectoring turns towards y = 0.
      if (mode_ff == CM_POLAR) begin
         pos = !z_ff[ANGLE_W-1];
      end else begin
         pos = !(!y_ff[CORDIC_W-1] && (|y_ff));
      end

      can_start = (state_ff == C_IDLE) || (state_ff == C_DONE);

      case (state_ff)
         C_INIT: begin
            y_in     = '0;
            cnt_in   = '0;
            state_in = C_ITER;
            if (z_ff > QUARTER) begin
               x_in = -x0;
               z_in = z_ff - HALF_TURN;
            end else if (z_ff < -QUARTER) begin
               x_in = -x0;
               z_in = z_ff + HALF_TURN;
            end else begin
               x_in = x0;
            end
         end
         C_ITER: begin
            if (pos) begin
               x_in = x_ff - sy;
               y_in = y_ff + sx;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + sy;
               y_in = y_ff - sx;
               z_in = z_ff + at;
            end
            if (cnt_ff == LAST) begin
               state_in = C_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         C_IDLE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase

      if (can_start && start) begin
         mode_in = cmd.mode;
         cnt_in  = '0;
         if (cmd.mode == CM_POLAR) begin
            prod_in  = cmd.len * GAIN_Q30;
            z_in     = {{(ANGLE_W-32){cmd.angle[15]}}, cmd.angle, 16'b0};
            state_in = C_INIT;
         end else begin
            if (dxe[CORDIC_W-1]) begin
               x_in = -dxe;
               y_in = -dye;
               z_in = HALF_TURN;
            end else begin
               x_in = dxe;
               y_in = dye;
               z_in = '0;
            end
            state_in = C_ITER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         cnt_ff   <= '0;
         mode_ff  <= CM_POLAR;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         mode_ff  <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      prod_ff <= prod_in;
   end

   // Results are rounded from the final rotator state.
   always_comb begin
      rx        = (x_ff + OUT_RND) >>> 8;
      ry        = (y_ff + OUT_RND) >>> 8;
      zr        = z_ff + ANG_RND;
      res.cx    = rx[DELTA_W-1:0];
      res.cy    = ry[DELTA_W-1:0];
      res.angle = zr[31:16];
   end

   assign done = (state_ff == C_DONE);

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == C_IDLE || state_ff == C_DONE))
      else $error("CORDIC start while a run is in progress");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("CORDIC done held for more than one cycle");

   a_iter_runs_on: assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_ITER && cnt_ff != LAST) |=> (state_ff == C_ITER))
      else $error("CORDIC left iteration before the last step");

endmodule

// ===== rtl/vehicle_kinematic_step.sv =====
// An advance item runs three rotations and one vectoring pass through the shared CORDIC
// unit, and leaves out the vectoring pass when front and rear coincide; a place item runs
// only one rotation. A stalled result holds the block in its output state.
// The block handles one item at a time: a new item is accepted only once the last one
// has left its output state.
// Synchronous active-high reset loads the default registers, zeroes the pose and clears the result valid flag.
// ----------------------------------------------------------------------------
// vehicle_kinematic_step: two-point kinematic bicycle model, one tick per item
// Keeps the rear axle point and heading, moves rear and front points by the
// configured velocity and derives the new heading from the front-rear vector.
// ----------------------------------------------------------------------------
module vehicle_kinematic_step
   import vks_pkg::*;
#(
   parameter int CORDIC_ITERATIONS      = CORDIC_ITERATIONS_DEF,
   parameter int POSITION_FRACTION_BITS = POSITION_FRACTION_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // The sequencer walks through the up to four CORDIC runs of an advance item.
   // A place item needs only the first run, which puts the front point one
   // wheel base ahead of the freshly loaded pose.
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RUN0 = 7'b0000010,
      S_RUN1 = 7'b0000100,
      S_RUN2 = 7'b0001000,
      S_VEC  = 7'b0010000,
      S_RUN3 = 7'b0100000,
      S_OUT  = 7'b1000000
   } seq_state_type;

   seq_state_type      state_ff, state_in;

   // Configuration registers.
   logic [15:0]        axle_gap_ff, axle_gap_in;
   logic [15:0]        speed_ff, speed_in;
   logic [31:0]        start_x_ff, start_x_in;
   logic [31:0]        start_y_ff, start_y_in;
   logic [15:0]        start_heading_ff, start_heading_in;

   // Vehicle state.
   logic signed [31:0] rear_x_ff, rear_x_in;
   logic signed [31:0] rear_y_ff, rear_y_in;
   logic [15:0]        heading_ff, heading_in;

   // Working registers of the current item.
   logic signed [31:0] front_x_ff, front_x_in;
   logic signed [31:0] front_y_ff, front_y_in;
   logic [15:0]        steer_ff, steer_in;
   logic               cmd_ff, cmd_in;

   // Result register.
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Shared CORDIC unit.
   logic               cstart;
   cordic_req_type     creq;
   logic               cdone;
   cordic_rsp_type     cres;

   logic signed [32:0] diff_x, diff_y;

   vks_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS),
      .FRAC_BITS  (POSITION_FRACTION_BITS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cstart),
      .cmd   (creq),
      .done  (cdone),
      .res   (cres)
   );

   // Configuration writes. Indexes beyond the register list are dropped.
   always_comb begin
      axle_gap_in      = axle_gap_ff;
      speed_in         = speed_ff;
      start_x_in       = start_x_ff;
      start_y_in       = start_y_ff;
      start_heading_in = start_heading_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_WHEEL_BASE:    axle_gap_in      = csr_wdata[15:0];
            CSR_VELOCITY:      speed_in         = csr_wdata[15:0];
            CSR_START_X:       start_x_in       = csr_wdata;
            CSR_START_Y:       start_y_in       = csr_wdata;
            CSR_START_HEADING: start_heading_in = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // The front-rear vector feeds the vectoring pass. Both ends are saturated
   // 32-bit positions, so the difference needs 33 bits.
   assign diff_x = {front_x_ff[31], front_x_ff} - {rear_x_ff[31], rear_x_ff};
   assign diff_y = {front_y_ff[31], front_y_ff} - {rear_y_ff[31], rear_y_ff};

   always_comb begin
      state_in     = state_ff;
      rear_x_in    = rear_x_ff;
      rear_y_in    = rear_y_ff;
      heading_in   = heading_ff;
      front_x_in   = front_x_ff;
      front_y_in   = front_y_ff;
      steer_in     = steer_ff;
      cmd_in       = cmd_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      cstart     = 1'b0;
      creq.mode  = CM_POLAR;
      creq.len   = {1'b0, axle_gap_ff};
      creq.angle = heading_ff;
      creq.dx    = diff_x;
      creq.dy    = diff_y;

      // The downstream side has taken the waiting item.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.command;
               steer_in = req_data.steer_angle;
               // The first run always places the front point one wheel base
               // ahead of the rear along the current heading.
               if (req_data.command == CMD_PLACE) begin
                  rear_x_in  = start_x_ff;
                  rear_y_in  = start_y_ff;
                  heading_in = start_heading_ff;
                  creq.angle = start_heading_ff;
               end
               cstart   = 1'b1;
               state_in = S_RUN0;
            end
         end
         S_RUN0: begin
            if (cdone) begin
               front_x_in = sat_add(rear_x_ff, cres.cx);
               front_y_in = sat_add(rear_y_ff, cres.cy);
               if (cmd_ff == CMD_PLACE) begin
                  state_in = S_OUT;
               end else begin
                  // Rear moves by velocity along the heading.
                  creq.len   = {speed_ff[15], speed_ff};
                  creq.angle = heading_ff;
                  cstart     = 1'b1;
                  state_in   = S_RUN1;
               end
            end
         end
         S_RUN1: begin
            if (cdone) begin
               rear_x_in  = sat_add(rear_x_ff, cres.cx);
               rear_y_in  = sat_add(rear_y_ff, cres.cy);
               // Front moves by velocity along heading plus steering, which
               // wraps round the full turn.
               creq.len   = {speed_ff[15], speed_ff};
               creq.angle = heading_ff + steer_ff;
               cstart     = 1'b1;
               state_in   = S_RUN2;
            end
         end
         S_RUN2: begin
            if (cdone) begin
               front_x_in = sat_add(front_x_ff, cres.cx);
               front_y_in = sat_add(front_y_ff, cres.cy);
               state_in   = S_VEC;
            end
         end
         S_VEC: begin
            // When front and rear coincide the old heading is kept.
            if ((|diff_x) || (|diff_y)) begin
               creq.mode = CM_VECTOR;
               cstart    = 1'b1;
               state_in  = S_RUN3;
            end else begin
               state_in = S_OUT;
            end
         end
         S_RUN3: begin
            if (cdone) begin
               heading_in = cres.angle;
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            // Wait for the result register to be free before finishing.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.rear_x  = round_coord(rear_x_ff, POSITION_FRACTION_BITS);
               rsp_data_in.rear_y  = round_coord(rear_y_ff, POSITION_FRACTION_BITS);
               rsp_data_in.front_x = round_coord(front_x_ff, POSITION_FRACTION_BITS);
               rsp_data_in.front_y = round_coord(front_y_ff, POSITION_FRACTION_BITS);
               rsp_data_in.heading = heading_ff;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         axle_gap_ff      <= WHEEL_BASE_RESET;
         speed_ff         <= VELOCITY_RESET;
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         start_heading_ff <= '0;
         rear_x_ff        <= '0;
         rear_y_ff        <= '0;
         heading_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         axle_gap_ff      <= axle_gap_in;
         speed_ff         <= speed_in;
         start_x_ff       <= start_x_in;
         start_y_ff       <= start_y_in;
         start_heading_ff <= start_heading_in;
         rear_x_ff        <= rear_x_in;
         rear_y_ff        <= rear_y_in;
         heading_ff       <= heading_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_x_ff  <= front_x_in;
      front_y_ff  <= front_y_in;
      steer_ff    <= steer_in;
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The block takes a new item only between items; the result register
   // decouples it from the downstream side.
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      cdone |-> (state_ff == S_RUN0 || state_ff == S_RUN1 ||
                 state_ff == S_RUN2 || state_ff == S_RUN3))
      else $error("CORDIC finished outside a run state");

   a_result_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && rsp_stall) |=>
         (state_ff == S_OUT && rsp_valid_ff))
      else $error("Pending result overwritten");

   a_place_one_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN0 && cdone && cmd_ff == CMD_PLACE) |=> (state_ff == S_OUT))
      else $error("Place item did not finish after its single run");

endmodule

// ===== verif/tb_vehicle_kinematic_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vehicle_kinematic_step: self-checking bench for the kinematic step block
// A pose tracker follows the rear point, heading and registers bit for bit
// and queues the expected pose of every accepted item. Results are compared
// field by field as they leave the block. A directed opening covers the
// extreme poses, steering wrap and zero-length headings. Random phases then
// run under changing settings and handshake idling.
// ----------------------------------------------------------------------------
module tb_vehicle_kinematic_step
   import vks_pkg::*;
();

   // The block is built with its default sizes, so the tracker uses them too.
   localparam int     FRAC          = POSITION_FRACTION_BITS_DEF;
   localparam int     CORDIC_STEPS  = (CORDIC_ITERATIONS_DEF > 24) ? 24 : CORDIC_ITERATIONS_DEF;
   localparam longint QUARTER_TURN  = longint'(1) << 30;
   localparam longint HALF_TURN     = longint'(1) << 31;
   localparam int     SEGMENTS      = 18;
   localparam int     SEGMENT_ITEMS = 60;
   localparam int     PRESSURE_SEG  = 12;
   localparam int     HOLD_CYCLES   = 400;
   localparam int     SETTLE_CYCLES = 4 * CORDIC_ITERATIONS_DEF + 40;
   localparam int     CYCLE_LIMIT   = 1_000_000;

   // Follows the vehicle pose and holds the poses that the block still owes.
   class pose_tracker;
      logic [15:0]        axle_gap;
      logic [15:0]        velocity;
      logic [31:0]        start_x;
      logic [31:0]        start_y;
      logic [15:0]        start_heading;
      logic signed [31:0] rear_x;
      logic signed [31:0] rear_y;
      logic [15:0]        heading;
      longint             atan_q32 [24];
      rsp_type            expected_poses [$];
      int                 failures;

      function new();
         axle_gap      = WHEEL_BASE_RESET;
         velocity      = VELOCITY_RESET;
         start_x       = '0;
         start_y       = '0;
         start_heading = '0;
         rear_x        = '0;
         rear_y        = '0;
         heading       = '0;
         failures      = 0;
         atan_q32 = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861, 10430, 5215,
                      2608, 1304, 652, 326, 163, 81};
      endfunction

      function void configure(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_WHEEL_BASE:    axle_gap      = value[15:0];
            CSR_VELOCITY:      velocity      = value[15:0];
            CSR_START_X:       start_x       = value;
            CSR_START_Y:       start_y       = value;
            CSR_START_HEADING: start_heading = value[15:0];
            default: ;
         endcase
      endfunction

      function logic signed [31:0] clamp32(input longint v);
         if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
         if (v < -64'sh8000_0000) return 32'sh8000_0000;
         return 32'(v);
      endfunction

      // Length along a 32-bit binary angle, by rotation with 8 guard bits.
      function void rotate_polar(input longint len, input logic [31:0] ang,
                                 output longint cx, output longint cy);
         longint x, y, z, nx, ny;
         x = (len * longint'(GAIN_Q30) + (longint'(1) << 21)) >>> 22;
         y = 0;
         z = longint'($signed(ang));
         if (z > QUARTER_TURN) begin
            x = -x;
            z = z - HALF_TURN;
         end else if (z < -QUARTER_TURN) begin
            x = -x;
            z = z + HALF_TURN;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               ny = y + (x >>> i);
               z  = z - atan_q32[i];
            end else begin
               nx = x + (y >>> i);
               ny = y - (x >>> i);
               z  = z + atan_q32[i];
            end
            x = nx;
            y = ny;
         end
         cx = (x + 128) >>> 8;
         cy = (y + 128) >>> 8;
      endfunction

      // Direction of a difference vector, rounded to a 16-bit binary angle.
      function logic [15:0] heading_of(input longint dx, input longint dy);
         longint      x, y, z, nx, ny;
         logic [63:0] rounded;
         x = dx * 256;
         y = dy * 256;
         z = 0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y > 0) begin
               nx = x + (y >>> i);
               ny = y - (x >>> i);
               z  = z + atan_q32[i];
            end else begin
               nx = x - (y >>> i);
               ny = y + (x >>> i);
               z  = z - atan_q32[i];
            end
            x = nx;
            y = ny;
         end
         rounded = z + 64'sd32768;
         return rounded[31:16];
      endfunction

      // Whole units, half away from zero, saturated to 16 bits.
      function logic [15:0] to_whole_units(input logic signed [31:0] p);
         longint r, half;
         half = longint'(1) << (FRAC - 1);
         if (p >= 0) r = (longint'(p) + half) >>> FRAC;
         else r = -((-longint'(p) + half) >>> FRAC);
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return 16'(r);
      endfunction

      function void note_step(input req_type item);
         longint             wb_len, v_len, ax, ay, fx, fy;
         logic signed [31:0] front_x, front_y;
         logic [15:0]        steer_heading;
         rsp_type            pose;
         wb_len = longint'(axle_gap) * (longint'(1) << (FRAC - 8));
         v_len  = longint'($signed(velocity)) * (longint'(1) << (FRAC - 8));
         if (item.command == CMD_PLACE) begin
            rear_x  = start_x;
            rear_y  = start_y;
            heading = start_heading;
            rotate_polar(wb_len, {heading, 16'h0000}, ax, ay);
            front_x = clamp32(longint'(rear_x) + ax);
            front_y = clamp32(longint'(rear_y) + ay);
         end else begin
            rotate_polar(wb_len, {heading, 16'h0000}, ax, ay);
            fx = clamp32(longint'(rear_x) + ax);
            fy = clamp32(longint'(rear_y) + ay);
            rotate_polar(v_len, {heading, 16'h0000}, ax, ay);
            rear_x = clamp32(longint'(rear_x) + ax);
            rear_y = clamp32(longint'(rear_y) + ay);
            steer_heading = heading + item.steer_angle;
            rotate_polar(v_len, {steer_heading, 16'h0000}, ax, ay);
            front_x = clamp32(fx + ax);
            front_y = clamp32(fy + ay);
            ax = longint'(front_x) - longint'(rear_x);
            ay = longint'(front_y) - longint'(rear_y);
            // A front point on top of the rear one leaves the heading alone.
            if (ax != 0 || ay != 0) heading = heading_of(ax, ay);
         end
         pose.rear_x  = to_whole_units(rear_x);
         pose.rear_y  = to_whole_units(rear_y);
         pose.front_x = to_whole_units(front_x);
         pose.front_y = to_whole_units(front_y);
         pose.heading = heading;
         expected_poses.insert(expected_poses.size(), pose);
      endfunction

      function void compare_field(input string name, input logic signed [15:0] want,
                                  input logic signed [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_pose(input rsp_type got);
         rsp_type want;
         if (expected_poses.size() == 0) begin
            $error("result with no item outstanding: %h", got);
            failures++;
            return;
         end
         want = expected_poses.pop_front();
         compare_field("rear_x", want.rear_x, got.rear_x);
         compare_field("rear_y", want.rear_y, got.rear_y);
         compare_field("front_x", want.front_x, got.front_x);
         compare_field("front_y", want.front_y, got.front_y);
         compare_field("heading", want.heading, got.heading);
      endfunction

      function int outstanding();
         return expected_poses.size();
      endfunction
   endclass

   // Every input starts at a known value; reset is high from time zero.
   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   req_type                req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   pose_tracker tracker;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic        hold_request  = 1'b0;
   logic        hold_done     = 1'b0;
   int          hold_left     = 0;
   int          cycle_count   = 0;

   always #5 clock = ~clock;

   vehicle_kinematic_step DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Receiver. Once asked, it holds off for a long stretch of its own so that
   // the block fills up and stalls new items; otherwise it stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Every accepted result is checked against the oldest outstanding pose.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_pose(rsp_data);
   end

   // Watchdog: a hung handshake must not run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_vehicle_kinematic_step: errors");
         $finish;
      end
   end

   // Offers one item, with random idle cycles ahead of it, and returns at the
   // edge where it is taken. Valid stays high so that items can run back to back.
   task automatic send_item(input logic command, input logic [15:0] steer);
      req_type item;
      item.command     = command;
      item.steer_angle = steer;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_step(item);
   endtask

   // Stops offering and waits until every outstanding pose has come back, so
   // that the registers may be written.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      tracker.configure(idx, value);
      @(posedge clock);
   endtask

   // Writes the whole set of registers. The upper half of the data of a
   // 16-bit register carries junk, which the block must drop.
   task automatic program_pose(input logic [15:0] axle_gap, input logic [15:0] velocity,
                               input logic [31:0] start_x, input logic [31:0] start_y,
                               input logic [15:0] start_heading);
      csr_write(CSR_WHEEL_BASE, {16'($urandom()), axle_gap});
      csr_write(CSR_VELOCITY, {16'($urandom()), velocity});
      csr_write(CSR_START_X, start_x);
      csr_write(CSR_START_Y, start_y);
      csr_write(CSR_START_HEADING, {16'($urandom()), start_heading});
   endtask

   initial begin
      logic [15:0] corner_steers [6];
      logic        command;
      logic [15:0] steer;

      tracker = new();
      corner_steers = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 16'h0001};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: steering at the quarter turns, both half turns and the
      // smallest step, then a place item whose steering must be ignored.
      foreach (corner_steers[i]) send_item(CMD_ADVANCE, corner_steers[i]);
      send_item(CMD_PLACE, 16'h1234);

      // No wheel base and no speed: front and rear coincide, the heading stays.
      drain_results();
      program_pose(16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h3000);
      send_item(CMD_PLACE, 16'h0000);
      send_item(CMD_ADVANCE, 16'h2000);

      // No wheel base and straight steering: both points move alike.
      drain_results();
      csr_write(CSR_VELOCITY, 32'd256);
      send_item(CMD_ADVANCE, 16'h0000);

      // Longest wheel base, fastest forward speed, poses at the range limits:
      // positions saturate and rounding runs past the 16-bit outputs.
      drain_results();
      program_pose(16'hFFFF, 16'h7FFF, 32'h7FFF_8000, 32'h8000_0000, 16'h8000);
      send_item(CMD_PLACE, 16'h0000);
      send_item(CMD_ADVANCE, 16'h0000);
      send_item(CMD_ADVANCE, 16'h7FFF);
      send_item(CMD_ADVANCE, 16'hC000);

      // Fastest reverse speed from the opposite corner.
      drain_results();
      program_pose(16'hFFFF, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
      send_item(CMD_PLACE, 16'h0000);
      send_item(CMD_ADVANCE, 16'h8000);

      // Writes to indexes beyond the register list must change nothing.
      drain_results();
      for (int idx = int'(CSR_START_HEADING) + 1; idx < (1 << CSR_INDEX_W); idx++) begin
         csr_write(CSR_INDEX_W'(idx), $urandom());
      end
      send_item(CMD_PLACE, 16'h0000);
      send_item(CMD_ADVANCE, 16'hFFFF);

      // Random phases. Each one places the vehicle and then drives it, mostly
      // with gentle steering under plausible settings, sometimes under wild ones.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_results();
         if (seg < SEGMENTS / 3) begin
            send_idle_pct = 8;
            recv_idle_pct <= 71;
         end else if (seg < 2 * SEGMENTS / 3) begin
            send_idle_pct = 71;
            recv_idle_pct <= 8;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         if (seg == PRESSURE_SEG) hold_request <= 1'b1;
         if ($urandom_range(4) == 0) begin
            program_pose(16'($urandom()), 16'($urandom()), $urandom(), $urandom(),
                         16'($urandom()));
         end else begin
            program_pose(16'($urandom_range(0, 16384)),
                         16'($urandom_range(0, 2048)) - 16'd1024,
                         32'($urandom_range(0, 262_144_000)) - 32'd131_072_000,
                         32'($urandom_range(0, 262_144_000)) - 32'd131_072_000,
                         16'($urandom()));
         end
         if ($urandom_range(3) == 0) begin
            csr_write(CSR_INDEX_W'($urandom_range(int'(CSR_START_HEADING) + 1,
                                                  (1 << CSR_INDEX_W) - 1)), $urandom());
         end
         send_item(CMD_PLACE, 16'($urandom()));
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            command = ($urandom_range(99) < 8) ? CMD_PLACE : CMD_ADVANCE;
            if ($urandom_range(9) < 7) steer = 16'($urandom_range(0, 16'h1FFF)) - 16'h1000;
            else steer = 16'($urandom());
            send_item(command, steer);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.outstanding() == 0) begin
         $display("tb_vehicle_kinematic_step: clean");
      end else begin
         $display("tb_vehicle_kinematic_step: errors");
      end
      $finish;
   end

endmodule
